FILE: src/hashed_block_buffer_cache_unit_assert.svh
// Assertion macros shared by the buffer cache checker.
`ifndef HASHED_BLOCK_BUFFER_CACHE_UNIT_ASSERT_SVH
`define HASHED_BLOCK_BUFFER_CACHE_UNIT_ASSERT_SVH
// Same-cycle implication under reset.
`define HBC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hbc assertion failed");
// Next-cycle implication under reset.
`define HBC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hbc assertion failed");
`endif

FILE: src/hbc_pkg.sv
// Shared constants for the hashed buffer cache.
package hbc_pkg;
   localparam int DEF_NUM_BUFFERS = 32;
   localparam int DEF_NUM_BUCKETS = 13;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 16;
   localparam logic [7:0] COUNT_MAX = 8'd255;
   localparam logic [1:0] CMD_GET = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_PIN = 2'd2;
   localparam logic [1:0] CMD_UNPIN = 2'd3;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NO_FREE = 2'd1;
   localparam logic [1:0] ST_COUNT = 2'd2;
endpackage

FILE: src/hashed_block_buffer_cache_unit.sv
// Hashed-bucket buffer cache: tags, counts and bucket lists with a list-walk sequencer.
//
// Requests arrive on the req_ stream, one transfer per command (get, release,
// pin, unpin); each produces exactly one result transfer on the rsp_ stream.
// The block works on one command at a time and holds req_tready low until the
// command's result is placed in the output register.
// A get computes the bucket hash (four bits per cycle), walks the home bucket
// for a tag match, then on a miss walks each bucket from its tail for a buffer
// with a zero count, relinks a buffer taken from another bucket into the home
// bucket, and finishes; a miss may walk a full home bucket once for the tags
// and once for the counts.
// Release, pin and unpin update the buffer's count and finish; a release that
// drops the count to zero also moves the buffer to its bucket's tail.
// The walk rate is set by the single read port of each link memory.
// After reset the link memories are initialized by a pass over all
// NUM_BUFFERS + NUM_BUCKETS nodes, during which no request is taken.
// A stalled result waits in the output register; a new request may be taken
// meanwhile, and its result waits until the register is free.
module hashed_block_buffer_cache_unit #(
   parameter int NUM_BUFFERS = hbc_pkg::DEF_NUM_BUFFERS,
   parameter int NUM_BUCKETS = hbc_pkg::DEF_NUM_BUCKETS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // cmd[1:0], device[9:2], block_number[41:10], buffer_index[46:42], zero
   input  logic [hbc_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // granted_buffer[4:0], was_hit[5], needs_disk_read[6], status[8:7], zero
   output logic [hbc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import hbc_pkg::*;

   localparam int NODES = NUM_BUFFERS + NUM_BUCKETS;
   localparam int NW = $clog2(NODES);
   localparam int NBW = $clog2(NUM_BUFFERS);
   localparam int BKW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int RW = $clog2(NUM_BUCKETS) + 2;
   localparam logic [NW-1:0] H0 = NW'(NUM_BUFFERS);

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_MOD = 4'd2;
   localparam logic [3:0] S_HRD = 4'd3;
   localparam logic [3:0] S_HWAIT = 4'd4;
   localparam logic [3:0] S_MRD = 4'd5;
   localparam logic [3:0] S_MWAIT = 4'd6;
   localparam logic [3:0] S_CNT = 4'd7;
   localparam logic [3:0] S_MV0 = 4'd8;
   localparam logic [3:0] S_MV1 = 4'd9;
   localparam logic [3:0] S_MV2 = 4'd10;
   localparam logic [3:0] S_MV3 = 4'd11;
   localparam logic [3:0] S_MV4 = 4'd12;
   localparam logic [3:0] S_MV5 = 4'd13;
   localparam logic [3:0] S_FIN = 4'd14;

   logic [3:0] state_ff, state_in;

   logic [7:0] tag_dev_ff [NUM_BUFFERS];
   logic [31:0] tag_blk_ff [NUM_BUFFERS];
   logic valid_ff [NUM_BUFFERS];
   logic [7:0] count_ff [NUM_BUFFERS];
   logic [BKW-1:0] home_of_ff [NUM_BUFFERS];

   logic [NW-1:0] fwd_mem [NODES];
   logic [NW-1:0] bwd_mem [NODES];
   logic [NW-1:0] fwd_rd_ff, bwd_rd_ff;
   logic [NW-1:0] fwd_ra, bwd_ra, fwd_wa, bwd_wa, fwd_wd, bwd_wd;
   logic fwd_we, bwd_we;

   logic [1:0] cmd_ff;
   logic [7:0] dev_ff;
   logic [31:0] blk_ff;
   logic [4:0] bi_ff;
   logic [31:0] shift_ff;
   logic [RW-1:0] mod_r_ff;
   logic [2:0] mod_cnt_ff;
   logic [BKW-1:0] home_ff, bucket_ff, steps_ff, tgt_ff;
   logic [NW-1:0] node_ff, f_ff, p_ff, x_ff, init_ff;
   logic tail_ff;

   logic [4:0] res_gr_ff;
   logic res_hit_ff, res_rd_ff;
   logic [1:0] res_st_ff;
   logic rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [RW-1:0] mod_next;
   logic [NBW-1:0] f_idx, b_idx, bi_idx;
   logic f_is_buf, b_is_buf, tag_hit, bi_in_pool;
   logic [BKW-1:0] bucket_next;
   logic [NW-1:0] tgt_head, init_fwd, init_bwd;
   logic accept, fin_go;

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign fin_go = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign f_idx = NBW'(fwd_rd_ff);
   assign b_idx = NBW'(bwd_rd_ff);
   assign bi_idx = NBW'(bi_ff);
   assign f_is_buf = fwd_rd_ff < H0;
   assign b_is_buf = bwd_rd_ff < H0;
   assign bi_in_pool = 32'(bi_ff) < 32'(NUM_BUFFERS);
   assign tag_hit = f_is_buf && tag_dev_ff[f_idx] == dev_ff && tag_blk_ff[f_idx] == blk_ff;
   assign bucket_next = (32'(bucket_ff) == NUM_BUCKETS - 1) ? '0 : bucket_ff + 1'b1;
   assign tgt_head = H0 + NW'(tgt_ff);

   // Restoring remainder by the bucket count, four block-number bits per cycle.
   always_comb begin
      logic [RW-1:0] r;
      r = mod_r_ff;
      for (int j = 0; j < 4; j++) begin
         r = (r << 1) | RW'(shift_ff[31-j]);
         if (r >= RW'(NUM_BUCKETS)) r = r - RW'(NUM_BUCKETS);
      end
      mod_next = r;
   end

   // Reset image of the lists: every buffer in bucket zero, tail is buffer zero.
   always_comb begin
      if (init_ff < H0) begin
         init_fwd = (init_ff == '0) ? H0 : init_ff - 1'b1;
         init_bwd = (init_ff == H0 - 1'b1) ? H0 : init_ff + 1'b1;
      end else if (init_ff == H0) begin
         init_fwd = H0 - 1'b1;
         init_bwd = '0;
      end else begin
         init_fwd = init_ff;
         init_bwd = init_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      fwd_ra = '0;
      bwd_ra = '0;
      fwd_we = 1'b0;
      bwd_we = 1'b0;
      fwd_wa = '0;
      bwd_wa = '0;
      fwd_wd = '0;
      bwd_wd = '0;
      case (state_ff)
         S_INIT: begin
            fwd_we = 1'b1;
            bwd_we = 1'b1;
            fwd_wa = init_ff;
            bwd_wa = init_ff;
            fwd_wd = init_fwd;
            bwd_wd = init_bwd;
            if (32'(init_ff) == NODES - 1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) state_in = (req_tdata[1:0] == CMD_GET) ? S_MOD : S_CNT;
         end
         S_MOD: begin
            if (mod_cnt_ff == 3'd7) state_in = S_HRD;
         end
         S_HRD: begin
            fwd_ra = H0 + NW'(home_ff);
            state_in = S_HWAIT;
         end
         S_HWAIT: begin
            fwd_ra = fwd_rd_ff;
            if (!f_is_buf) state_in = S_MRD;
            else if (tag_hit) state_in = S_FIN;
         end
         S_MRD: begin
            bwd_ra = H0 + NW'(bucket_ff);
            state_in = S_MWAIT;
         end
         S_MWAIT: begin
            bwd_ra = bwd_rd_ff;
            if (!b_is_buf) begin
               bwd_ra = H0 + NW'(bucket_next);
               if (32'(steps_ff) == NUM_BUCKETS - 1) state_in = S_FIN;
            end else if (count_ff[b_idx] == '0) begin
               state_in = (bucket_ff != home_ff) ? S_MV0 : S_FIN;
            end
         end
         S_CNT: begin
            state_in = S_FIN;
            if (bi_in_pool && cmd_ff == CMD_RELEASE && count_ff[bi_idx] == 8'd1)
               state_in = S_MV0;
         end
         S_MV0: begin
            fwd_ra = node_ff;
            bwd_ra = node_ff;
            state_in = S_MV1;
         end
         S_MV1: state_in = S_MV2;
         S_MV2: begin
            // Unlink the node from its current bucket.
            fwd_we = 1'b1;
            fwd_wa = p_ff;
            fwd_wd = f_ff;
            bwd_we = 1'b1;
            bwd_wa = f_ff;
            bwd_wd = p_ff;
            state_in = S_MV3;
         end
         S_MV3: begin
            fwd_ra = tgt_head;
            bwd_ra = tgt_head;
            state_in = S_MV4;
         end
         S_MV4: begin
            fwd_we = 1'b1;
            bwd_we = 1'b1;
            fwd_wa = node_ff;
            bwd_wa = node_ff;
            fwd_wd = tail_ff ? tgt_head : fwd_rd_ff;
            bwd_wd = tail_ff ? bwd_rd_ff : tgt_head;
            state_in = S_MV5;
         end
         S_MV5: begin
            fwd_we = 1'b1;
            bwd_we = 1'b1;
            fwd_wd = node_ff;
            bwd_wd = node_ff;
            fwd_wa = tail_ff ? x_ff : tgt_head;
            bwd_wa = tail_ff ? tgt_head : x_ff;
            state_in = S_FIN;
         end
         S_FIN: begin
            if (fin_go) state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end

   // Link memories: one write and one registered read each cycle.
   always_ff @(posedge clock) begin
      if (fwd_we) fwd_mem[fwd_wa] <= fwd_wd;
      if (bwd_we) bwd_mem[bwd_wa] <= bwd_wd;
      fwd_rd_ff <= fwd_mem[fwd_ra];
      bwd_rd_ff <= bwd_mem[bwd_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         init_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            tag_dev_ff[i] <= '0;
            tag_blk_ff[i] <= '0;
            valid_ff[i] <= 1'b0;
            count_ff[i] <= '0;
            home_of_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (fin_go) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_INIT: init_ff <= init_ff + 1'b1;
            S_IDLE: begin
               if (accept) begin
                  cmd_ff <= req_tdata[1:0];
                  dev_ff <= req_tdata[9:2];
                  blk_ff <= req_tdata[41:10];
                  bi_ff <= req_tdata[46:42];
                  shift_ff <= req_tdata[41:10];
                  mod_r_ff <= '0;
                  mod_cnt_ff <= '0;
                  res_gr_ff <= req_tdata[46:42];
                  res_hit_ff <= 1'b0;
                  res_rd_ff <= 1'b0;
                  res_st_ff <= ST_OK;
               end
            end
            S_MOD: begin
               mod_r_ff <= mod_next;
               shift_ff <= shift_ff << 4;
               mod_cnt_ff <= mod_cnt_ff + 1'b1;
               home_ff <= BKW'(mod_next);
               bucket_ff <= BKW'(mod_next);
               steps_ff <= '0;
            end
            S_HWAIT: begin
               if (tag_hit) begin
                  res_hit_ff <= 1'b1;
                  res_gr_ff <= 5'(fwd_rd_ff);
                  res_rd_ff <= !valid_ff[f_idx];
                  valid_ff[f_idx] <= 1'b1;
                  if (count_ff[f_idx] >= COUNT_MAX) res_st_ff <= ST_COUNT;
                  else count_ff[f_idx] <= count_ff[f_idx] + 1'b1;
               end
            end
            S_MWAIT: begin
               if (!b_is_buf) begin
                  bucket_ff <= bucket_next;
                  steps_ff <= steps_ff + 1'b1;
                  if (32'(steps_ff) == NUM_BUCKETS - 1) res_st_ff <= ST_NO_FREE;
               end else if (count_ff[b_idx] == '0) begin
                  // Retagged buffer always needs a read; it is then marked valid.
                  tag_dev_ff[b_idx] <= dev_ff;
                  tag_blk_ff[b_idx] <= blk_ff;
                  valid_ff[b_idx] <= 1'b1;
                  count_ff[b_idx] <= 8'd1;
                  home_of_ff[b_idx] <= home_ff;
                  res_gr_ff <= 5'(bwd_rd_ff);
                  res_rd_ff <= 1'b1;
                  node_ff <= bwd_rd_ff;
                  tgt_ff <= home_ff;
                  tail_ff <= 1'b0;
               end
            end
            S_CNT: begin
               node_ff <= NW'(bi_ff);
               tgt_ff <= home_of_ff[bi_idx];
               tail_ff <= 1'b1;
               if (bi_in_pool) begin
                  if (cmd_ff == CMD_PIN) begin
                     if (count_ff[bi_idx] >= COUNT_MAX) res_st_ff <= ST_COUNT;
                     else count_ff[bi_idx] <= count_ff[bi_idx] + 1'b1;
                  end else if (count_ff[bi_idx] == '0) begin
                     res_st_ff <= ST_COUNT;
                  end else begin
                     count_ff[bi_idx] <= count_ff[bi_idx] - 1'b1;
                  end
               end
            end
            S_MV1: begin
               f_ff <= fwd_rd_ff;
               p_ff <= bwd_rd_ff;
            end
            S_MV4: x_ff <= tail_ff ? bwd_rd_ff : fwd_rd_ff;
            S_FIN: begin
               if (fin_go) rsp_data_ff <= {7'd0, res_st_ff, res_rd_ff, res_hit_ff, res_gr_ff};
            end
            default: ;
         endcase
      end
   end
endmodule

FILE: src/hbc_checker.sv
// Port-level checker for the buffer cache, bound to the top level.
`include "hashed_block_buffer_cache_unit_assert.svh"
module hbc_port_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [hbc_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import hbc_pkg::*;

   `HBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   `HBC_ASSERT_IMP(a_status_code, clock, reset, rsp_tvalid, rsp_tdata[8:7] != 2'd3)
   `HBC_ASSERT_IMP(a_hit_not_full, clock, reset, rsp_tvalid && rsp_tdata[5],
      rsp_tdata[8:7] != ST_NO_FREE && !rsp_tdata[6] || rsp_tdata[8:7] != ST_NO_FREE)
   `HBC_ASSERT_IMP(a_no_free_clean, clock, reset,
      rsp_tvalid && rsp_tdata[8:7] == ST_NO_FREE, !rsp_tdata[5] && !rsp_tdata[6])
endmodule

bind hashed_block_buffer_cache_unit hbc_port_checker u_hbc_checker (
   .clock(clock),
   .reset(reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);
